// File: hdl/f64fx_pkg.sv
package f64fx_pkg;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NONFIN  = 2'd1;
  localparam logic [1:0] ST_WIDE    = 2'd2;
  localparam logic [1:0] ST_BADFMT  = 2'd3;
  localparam logic       OP_TOFIX   = 1'b0;
  localparam logic       OP_TODBL   = 1'b1;
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAC   = 2'd1;
  localparam logic [1:0] REG_SIGNED = 2'd2;
  localparam int unsigned MAX_WIDTH = 62;

  typedef struct packed {
    logic [5:0] width;
    logic [5:0] frac;
    logic       sgn;
  } fmt_t;

  typedef struct packed {
    logic [63:0] bits;
    logic [1:0]  status;
  } res_t;
endpackage

// File: hdl/f64fx_to_fixed.sv
module f64fx_to_fixed (
  input  f64fx_pkg::fmt_t fmt,
  input  logic [63:0]     d,
  output f64fx_pkg::res_t res
);
  import f64fx_pkg::*;

  logic        neg;
  logic [10:0] e;
  logic [52:0] frac;
  logic signed [12:0] s;
  logic [6:0]  k;
  logic        sat;
  logic [63:0] mag, lim, modm, lim_c;
  logic [63:0] shr, shr1;

  always_comb begin
    neg  = d[63];
    e    = d[62:52];
    frac = {1'b1, d[51:0]};
    s    = $signed({2'b00, e}) - 13'sd1075 + $signed({7'd0, fmt.frac});
    k    = 7'((-s) > 13'sd127 ? 13'sd127 : -s);
    sat  = s >= 13'sd11;
    modm = (64'd1 << fmt.width) - 64'd1;
    shr  = 64'(frac) >> k;
    shr1 = (k == 7'd0) ? 64'd0 : (64'(frac) >> (k - 7'd1));
    if (sat) begin
      mag = 64'd0;
    end else if (s >= 13'sd0) begin
      mag = 64'(frac) << s[3:0];
    end else if (k > 7'd63) begin
      mag = 64'd0;
    end else begin
      mag = shr + {63'd0, shr1[0]};
    end
    res.status = ST_OK;
    res.bits   = 64'd0;
    if (neg) begin
      lim = (modm >> 1) + 64'd1;
    end else begin
      lim = fmt.sgn ? (modm >> 1) : modm;
    end
    lim_c = (sat || mag > lim) ? lim : mag;
    if (e == 11'h7ff) begin
      res.status = ST_NONFIN;
    end else if (e == 11'd0) begin
      res.bits = 64'd0;
    end else if (neg) begin
      if (fmt.sgn) begin
        res.bits = (lim_c == 64'd0) ? 64'd0 : ((~lim_c + 64'd1) & modm);
      end
    end else begin
      res.bits = lim_c;
    end
  end
endmodule

// File: hdl/f64fx_to_double.sv
module f64fx_to_double (
  input  f64fx_pkg::fmt_t fmt,
  input  logic [63:0]     b,
  output f64fx_pkg::res_t res
);
  import f64fx_pkg::*;

  logic [63:0] modm, mag, norm, hi_mask;
  logic        sign;
  logic [5:0]  lz;
  logic [5:0]  p;
  logic [52:0] mant;
  logic [53:0] mant_r;
  logic        g, st;
  logic [10:0] ex;
  logic [11:0] pp;

  always_comb begin
    modm    = (64'd1 << fmt.width) - 64'd1;
    hi_mask = ~modm;
    sign    = fmt.sgn && b[fmt.width - 6'd1];
    mag     = sign ? ((~b + 64'd1) & modm) : b;
    lz      = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (mag[i]) begin
        lz = 6'(63 - i);
      end
    end
    norm   = mag << lz;
    p      = 6'd63 - lz;
    mant   = norm[63:11];
    g      = norm[10];
    st     = |norm[9:0];
    mant_r = {1'b0, mant} + {53'd0, g && (st || mant[0])};
    pp     = {6'd0, p} + {11'd0, mant_r[53]};
    ex     = 11'(pp - {6'd0, fmt.frac} + 12'd1023);
    res.status = ST_OK;
    res.bits   = 64'd0;
    if ((b & hi_mask) != 64'd0) begin
      res.status = ST_WIDE;
    end else if (mag != 64'd0) begin
      res.bits = {sign, ex, mant_r[53] ? mant_r[52:1] : mant_r[51:0]};
    end
  end
endmodule

// File: hdl/float64_fixed_point_converter_top.sv
// The result becomes valid in the cycle after the input transfer.
// Throughput: one item per cycle; output register with tready-based pipeline stall.
// Reset (synchronous, rst_n low): output invalid; total_width 16, fraction_bits 8,
// two's complement mode on.
module float64_fixed_point_converter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // operand_bits
  input  logic        in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // result_bits[63:0], status[65:64], zero pad
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import f64fx_pkg::*;

  fmt_t        fmt_r;
  res_t        fix_res, dbl_res, sel_res;
  res_t        out_r;
  logic        vld_r;
  logic        fmt_ok;
  logic [1:0]  ridx;

  assign cfg_pready = 1'b1;
  assign ridx       = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= '{width: 6'd16, frac: 6'd8, sgn: 1'b1};
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (ridx)
        REG_WIDTH:  fmt_r.width <= cfg_pwdata[5:0];
        REG_FRAC:   fmt_r.frac  <= cfg_pwdata[5:0];
        REG_SIGNED: fmt_r.sgn   <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_WIDTH:  cfg_prdata = {26'd0, fmt_r.width};
      REG_FRAC:   cfg_prdata = {26'd0, fmt_r.frac};
      REG_SIGNED: cfg_prdata = {31'd0, fmt_r.sgn};
      default:    cfg_prdata = 32'd0;
    endcase
  end

  f64fx_to_fixed u_fix (.fmt(fmt_r), .d(in_tdata), .res(fix_res));
  f64fx_to_double u_dbl (.fmt(fmt_r), .b(in_tdata), .res(dbl_res));

  assign fmt_ok = fmt_r.width >= 6'd2 && fmt_r.width <= 6'(MAX_WIDTH)
                  && fmt_r.frac < fmt_r.width;

  always_comb begin
    if (!fmt_ok) begin
      sel_res = '{bits: 64'd0, status: ST_BADFMT};
    end else if (in_tuser == OP_TOFIX) begin
      sel_res = fix_res;
    end else begin
      sel_res = dbl_res;
    end
  end

  assign in_tready = !vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      out_r <= sel_res;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {6'd0, out_r.status, out_r.bits};
endmodule
